// ===== rtl/core/lpfd_pkg.sv =====
`timescale 1ns / 1ps

package lpfd_pkg;

    // Default header length in bytes (magic, version, length, reserved)
    localparam int HEADER_BYTES_DEF = 16;

    // Fixed header layout: byte offsets where each field ends
    localparam int MAGIC_END   = 4;
    localparam int VERSION_END = 6;
    localparam int LENGTH_END  = 10;

    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_BYTE        = 2'd0;
    localparam logic [1:0] KIND_EMPTY       = 2'd1;
    localparam logic [1:0] KIND_BAD_MAGIC   = 2'd2;
    localparam logic [1:0] KIND_BAD_VERSION = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last_of_frame;
    } t_result;

endpackage

// ===== rtl/core/lpfd_parser.sv =====
`timescale 1ns / 1ps

module lpfd_parser #(
    parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [lpfd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_accept,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_restart,
    output logic                           o_res_valid,
    output lpfd_pkg::t_result              o_res
);
    import lpfd_pkg::*;

    localparam int POS_W = $clog2(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    logic [31:0]      r_exp_magic;
    logic [15:0]      r_exp_version;
    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_magic, n_magic;
    logic [15:0]      r_version, n_version;
    logic [31:0]      r_rem, n_rem;
    logic [31:0]      rem_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAGIC:   r_exp_magic   <= i_cfg_data;
                CFG_VERSION: r_exp_version <= i_cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    assign rem_dec = r_rem - 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_magic     = r_magic;
        n_version   = r_version;
        n_rem       = r_rem;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_BYTE, payload_byte: 8'd0, last_of_frame: 1'b0};
        if (i_accept) begin
            if (i_restart) begin
                n_phase = PH_HEADER;
                n_pos   = '0;
                n_rem   = '0;
            end else begin
                case (r_phase)
                    PH_PAYLOAD: begin
                        o_res_valid        = 1'b1;
                        o_res.payload_byte = i_rx_byte;
                        o_res.last_of_frame = (rem_dec == 32'd0);
                        n_rem              = rem_dec;
                        if (rem_dec == 32'd0) begin
                            n_phase = PH_HEADER;
                        end
                    end
                    PH_HEADER: begin
                        // shift the byte into whichever field it belongs to
                        if (r_pos < POS_W'(MAGIC_END)) begin
                            n_magic = {r_magic[23:0], i_rx_byte};
                        end else if (r_pos < POS_W'(VERSION_END)) begin
                            n_version = {r_version[7:0], i_rx_byte};
                        end else if (r_pos < POS_W'(LENGTH_END)) begin
                            n_rem = {r_rem[23:0], i_rx_byte};
                        end
                        if (r_pos != POS_LAST) begin
                            n_pos = r_pos + POS_W'(1);
                        end else begin
                            n_pos = '0;
                            if (n_magic != r_exp_magic) begin
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_BAD_MAGIC;
                                n_phase     = PH_HALTED;
                            end else if (n_version != r_exp_version) begin
                                o_res_valid = 1'b1;
                                o_res.kind  = KIND_BAD_VERSION;
                                n_phase     = PH_HALTED;
                            end else if (n_rem == 32'd0) begin
                                o_res_valid         = 1'b1;
                                o_res.kind          = KIND_EMPTY;
                                o_res.last_of_frame = 1'b1;
                                n_phase             = PH_HEADER;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    default: ;  // halted: drop the byte
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_pos     <= '0;
            r_rem     <= '0;
            r_magic   <= '0;
            r_version <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_rem     <= n_rem;
            r_magic   <= n_magic;
            r_version <= n_version;
        end
    end

`ifndef SYNTHESIS
    a_res_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_accept)
        else $error("result without an accepted transaction");
    a_payload_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_rem != 32'd0))
        else $error("payload phase with no bytes remaining");
    a_pos_only_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != '0) |-> (r_phase == PH_HEADER))
        else $error("header position moved outside header phase");
    a_halt_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_BAD_MAGIC || o_res.kind == KIND_BAD_VERSION))
        |=> (r_phase == PH_HALTED))
        else $error("error result did not halt the parser");
`endif

endmodule

// ===== rtl/core/lpfd_out_buf.sv =====
`timescale 1ns / 1ps

module lpfd_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpfd_pkg::t_result i_res,
    output logic              o_in_ready,
    output logic              o_valid,
    output lpfd_pkg::t_result o_res,
    input  logic              i_ready
);
    import lpfd_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    out_free;

    // take new transactions as long as the skid slot is empty
    assign o_in_ready = !r_skid_valid;
    assign out_free   = !r_out_valid || i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_res;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// ===== rtl/core/length_prefixed_frame_deframer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Ports            Contents
// s_axis    in         tdata, tuser     rx_byte / restart flag
// m_axis    out        tdata, tuser,    payload_byte / kind /
//                      tlast            last_of_frame
// cfg       in         we, addr, data   expected_magic (0), expected_version (1)
//
// One byte per cycle while s_axis_tready is high: every transaction is parsed
// in the cycle it is accepted and any result lands, on the next edge, in the
// output register or, under an m_axis stall, in the skid entry. This two-entry
// stage holds results; s_axis_tready drops only while both entries are full.
// Reset is synchronous, active low; it clears the parser to header phase and
// both configuration registers to zero.

module length_prefixed_frame_deframer #(
    parameter int HEADER_BYTES = lpfd_pkg::HEADER_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [lpfd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
    input  logic                           s_axis_tuser,   // [0] restart
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] payload_byte
    output logic [1:0]                     m_axis_tuser,   // [1:0] kind
    output logic                           m_axis_tlast    // last_of_frame
);
    import lpfd_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // a transaction moves on every edge where valid meets ready
    assign accept = s_axis_tvalid && s_axis_tready;

    // Parse the byte against header / payload / halt state
    lpfd_parser #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_rx_byte  (s_axis_tdata),
        .i_restart  (s_axis_tuser),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // Hold results until the downstream side takes them
    lpfd_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res_valid),
        .i_res     (res),
        .o_in_ready(s_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_res     (out_res),
        .i_ready   (m_axis_tready)
    );

    assign m_axis_tdata = out_res.payload_byte;
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_of_frame;

endmodule

// ===== sim/length_prefixed_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_tb;

    import lpfd_pkg::*;

    localparam int HDR_BYTES         = HEADER_BYTES_DEF;
    localparam int ITEMS_PER_SETTING = 300;
    localparam int N_SETTINGS        = 6;
    // Results are registered after their byte; leave room for the skid entry too
    localparam int SETTLE_CYCLES     = 6;

    // One stream byte plus, for directed rows, the result typed in by hand
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
        logic       typed;
        logic       has_result;
        t_result    result;
    } t_rx_row;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_HALTED
    } t_parse_phase;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_BLOCKS
    } t_sink_mode;

    localparam t_result NO_RESULT  = '{KIND_BYTE, 8'h00, 1'b0};
    localparam t_result MAGIC_FAIL = '{KIND_BAD_MAGIC, 8'h00, 1'b0};

    // Directed opening: restart right after reset, a header whose magic and
    // version are both wrong (magic must win), bytes swallowed while halted,
    // restart out of the halt, then a partial header dropped by a restart.
    localparam int DIRECTED_LEN = 24;
    localparam t_rx_row DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{8'hFF, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b1, 1'b1, MAGIC_FAIL},
        '{8'h5A, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{8'hA5, 1'b1, 1'b1, 1'b0, NO_RESULT}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [7:0] rx_byte
    logic                 s_axis_tuser  = 1'b0; // [0] restart
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [7:0] payload_byte
    logic [1:0]           m_axis_tuser;         // [1:0] kind
    logic                 m_axis_tlast;         // last_of_frame

    // Predicted parser state and a copy of the configuration registers
    t_parse_phase parse_phase;
    int           hdr_index;
    logic [31:0]  magic_acc;
    logic [15:0]  version_acc;
    logic [31:0]  len_left;
    logic [31:0]  want_magic;
    logic [15:0]  want_version;

    t_rx_row      rx_stream_q[$];
    t_result      deframed_q[$];
    int           mismatch_count;
    int           stream_items;

    // Sender and receiver pacing
    t_rx_row      cur_row;
    int           burst_left;
    int           gap_left;
    t_sink_mode   sink_mode;
    int           sink_span;
    int           sink_hold;
    logic         sink_level;
    t_result      seen_want;

    length_prefixed_frame_deframer #(
        .HEADER_BYTES (HDR_BYTES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("[length_prefixed_frame_deframer] ERROR");
        $finish;
    end

    function automatic void clear_parser();
        parse_phase = PH_HEADER;
        hdr_index   = 0;
        magic_acc   = '0;
        version_acc = '0;
        len_left    = '0;
    endfunction

    // Advance the parser by one stream byte; return 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] rx, input logic restart,
                                        output t_result res);
        res = NO_RESULT;
        if (restart) begin
            clear_parser();
            return 1'b0;
        end
        if (parse_phase == PH_PAYLOAD) begin
            len_left         = len_left - 32'd1;
            res.kind         = KIND_BYTE;
            res.payload_byte = rx;
            res.last_of_frame = (len_left == 32'd0);
            if (len_left == 32'd0)
                clear_parser();
            return 1'b1;
        end
        // Halted (and the unused phase code) swallow everything but restart
        if (parse_phase != PH_HEADER)
            return 1'b0;

        if (hdr_index < MAGIC_END)
            magic_acc = {magic_acc[23:0], rx};
        else if (hdr_index < VERSION_END)
            version_acc = {version_acc[7:0], rx};
        else if (hdr_index < LENGTH_END)
            len_left = {len_left[23:0], rx};

        if (hdr_index + 1 < HDR_BYTES) begin
            hdr_index++;
            return 1'b0;
        end
        hdr_index = 0;
        // Magic check wins when both fail
        if (magic_acc != want_magic) begin
            res.kind    = KIND_BAD_MAGIC;
            parse_phase = PH_HALTED;
            return 1'b1;
        end
        if (version_acc != want_version) begin
            res.kind    = KIND_BAD_VERSION;
            parse_phase = PH_HALTED;
            return 1'b1;
        end
        if (len_left == 32'd0) begin
            res.kind          = KIND_EMPTY;
            res.last_of_frame = 1'b1;
            clear_parser();
            return 1'b1;
        end
        parse_phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        if (idx == CFG_MAGIC)
            want_magic = value;
        else
            want_version = value[15:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic push_item(input logic [7:0] rx, input logic restart, input bit counts);
        t_rx_row row;
        row         = '0;
        row.rx_byte = rx;
        row.restart = restart;
        rx_stream_q.push_back(row);
        if (counts)
            stream_items++;
    endtask

    // Big-endian magic, version, length, then random reserved bytes
    task automatic push_header(input logic [31:0] magic, input logic [15:0] version,
                               input logic [31:0] len);
        logic [8*LENGTH_END-1:0] fields;
        fields = {magic, version, len};
        for (int i = 0; i < LENGTH_END; i++)
            push_item(fields[8*(LENGTH_END-i)-1 -: 8], 1'b0, 1'b1);
        for (int i = LENGTH_END; i < HDR_BYTES; i++)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // A few bytes the halted parser must drop, then restart out of the halt
    task automatic push_halt_tail();
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
            push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    endtask

    // Mostly well-formed frames with random content; the rest are bad headers,
    // frames cut short by restart, and raw noise.
    task automatic gen_frame();
        int          pick;
        int          n;
        logic [31:0] len;
        logic [31:0] flip;
        logic [15:0] version;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
            n = $urandom_range(0, 19);
            if (n < 2) begin
                len = '0;
            end else if (n < 3) begin
                // Huge length: send a slice of payload, then cut it with restart
                len     = $urandom();
                len[24] = 1'b1;
            end else begin
                len = $urandom_range(1, 40);
            end
            push_header(want_magic, want_version, len);
            n = (len > 48) ? $urandom_range(1, 24) : int'(len);
            if (n > 1 && $urandom_range(0, 19) == 0)
                n = $urandom_range(1, n - 1);
            for (int i = 0; i < n; i++)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            if (n < len)
                push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end else if (pick < 74) begin
            flip = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 31)) : $urandom();
            if (flip == '0)
                flip = 32'h1;
            version = $urandom_range(0, 1) ? want_version : 16'($urandom_range(0, 65535));
            push_header(want_magic ^ flip, version, $urandom());
            push_halt_tail();
        end else if (pick < 86) begin
            flip = $urandom_range(0, 1) ? (32'h1 << $urandom_range(0, 15))
                                        : 32'($urandom_range(1, 65535));
            push_header(want_magic, want_version ^ flip[15:0], $urandom());
            push_halt_tail();
        end else if (pick < 93) begin
            n = $urandom_range(1, HDR_BYTES - 1);
            for (int i = 0; i < n; i++)
                push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end else begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
                push_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), 1'b1);
            push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
    endtask

    // Hold until the stream is drained and every predicted result has arrived
    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (rx_stream_q.size() != 0 || s_axis_tvalid || deframed_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sender: bursts of random length separated by random gaps (often none).
    // A presented byte holds until its transaction completes.
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            t_result res;
            bit      due;
            due = deframe_byte(cur_row.rx_byte, cur_row.restart, res);
            if (cur_row.typed) begin
                due = cur_row.has_result;
                res = cur_row.result;
            end
            if (due)
                deframed_q.push_back(res);
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_stream_q.size() != 0) begin
                cur_row = rx_stream_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cur_row.rx_byte;
                s_axis_tuser  <= cur_row.restart;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switch between open, coin-flip, mostly-ready and long-stall spans
    always @(posedge i_clk) begin
        if (sink_span == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            sink_span = $urandom_range(16, 160);
        end else begin
            sink_span--;
        end
        case (sink_mode)
            SINK_OPEN: begin
                m_axis_tready <= 1'b1;
            end
            SINK_COIN: begin
                m_axis_tready <= 1'($urandom_range(0, 1));
            end
            SINK_MOSTLY: begin
                m_axis_tready <= ($urandom_range(0, 7) != 0);
            end
            default: begin
                if (sink_hold == 0) begin
                    sink_level = !sink_level;
                    sink_hold  = $urandom_range(1, 12);
                end else begin
                    sink_hold--;
                end
                m_axis_tready <= sink_level;
            end
        endcase
    end

    // Compare every output transaction with the oldest predicted result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (deframed_q.size() == 0) begin
                report_mismatch("unexpected result kind", 32'(m_axis_tuser), 32'hFFFF_FFFF);
            end else begin
                seen_want = deframed_q.pop_front();
                if (m_axis_tuser !== seen_want.kind)
                    report_mismatch("kind", 32'(m_axis_tuser), 32'(seen_want.kind));
                if (m_axis_tdata !== seen_want.payload_byte)
                    report_mismatch("payload_byte", 32'(m_axis_tdata),
                                    32'(seen_want.payload_byte));
                if (m_axis_tlast !== seen_want.last_of_frame)
                    report_mismatch("last_of_frame", 32'(m_axis_tlast),
                                    32'(seen_want.last_of_frame));
            end
        end
    end

    initial begin
        logic [31:0] magic_set;
        logic [15:0] version_set;
        want_magic     = '0;
        want_version   = '0;
        mismatch_count = 0;
        stream_items   = 0;
        burst_left     = 0;
        gap_left       = 0;
        sink_mode      = SINK_OPEN;
        sink_span      = 0;
        sink_hold      = 0;
        sink_level     = 1'b1;
        clear_parser();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows run against the reset configuration (both zero)
        for (int r = 0; r < DIRECTED_LEN; r++)
            rx_stream_q.push_back(DIRECTED_ROWS[r]);
        wait_idle();

        // Walk the register extremes, then random settings; each setting is
        // written only after the sender has paused and all results are in.
        for (int s = 0; s < N_SETTINGS; s++) begin
            case (s)
                0: begin
                    magic_set   = 32'hFFFF_FFFF;
                    version_set = 16'hFFFF;
                end
                1: begin
                    magic_set   = 32'h0000_0000;
                    version_set = 16'hFFFF;
                end
                2: begin
                    magic_set   = 32'hFFFF_FFFF;
                    version_set = 16'h0000;
                end
                default: begin
                    magic_set   = $urandom();
                    version_set = 16'($urandom_range(0, 65535));
                end
            endcase
            write_reg(CFG_MAGIC, magic_set);
            write_reg(CFG_VERSION, {16'h0000, version_set});
            stream_items = 0;
            while (stream_items < ITEMS_PER_SETTING)
                gen_frame();
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("[length_prefixed_frame_deframer] OK");
        end else begin
            $display("[length_prefixed_frame_deframer] ERROR");
        end
        $finish;
    end

endmodule
